[design/sorted_list_insert_remove_macros.svh]
// ----------------------------------------------------------------------------
// Sorted list store: assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_INSERT_REMOVE_MACROS_SVH
`define SORTED_LIST_INSERT_REMOVE_MACROS_SVH

// same-cycle implication
`define SLRI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle assertion failed");

// next-cycle implication
`define SLRI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle assertion failed");

`endif

[design/slri_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted list store: package
// Request/result payload types, request and status codes, default size.
// ----------------------------------------------------------------------------
package slri_pkg;

	localparam int DEFAULT_CAPACITY = 64;
	localparam int VALUE_W          = 32;

	// request codes
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	// status codes
	localparam logic [1:0] STATUS_DONE     = 2'd0;
	localparam logic [1:0] STATUS_NOTFOUND = 2'd1;
	localparam logic [1:0] STATUS_FULL     = 2'd2;

	typedef struct packed {
		logic                      req_type;
		logic signed [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [6:0] entry_count;
	} resp_t;

endpackage

[design/slri_mem.sv]
// ----------------------------------------------------------------------------
// Sorted list store: entry memory
// Simple dual-port synchronous RAM, one write and one read per cycle,
// registered read data.
// ----------------------------------------------------------------------------
module slri_mem #(
	parameter int DEPTH = slri_pkg::DEFAULT_CAPACITY,
	parameter int AW    = $clog2(slri_pkg::DEFAULT_CAPACITY)
) (
	input  logic                               clk,
	input  logic                               we,
	input  logic [AW-1:0]                      waddr,
	input  logic signed [slri_pkg::VALUE_W-1:0] wdata,
	input  logic                               re,
	input  logic [AW-1:0]                      raddr,
	output logic signed [slri_pkg::VALUE_W-1:0] rdata
);

	logic signed [slri_pkg::VALUE_W-1:0] mem [DEPTH];
	logic signed [slri_pkg::VALUE_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[design/sorted_list_insert_remove.sv]
// An insert scans the held entries, writes the tail slot and finishes; a
// remove scans and finishes. An empty store skips the scan, and an insert
// into a full store goes straight to the finish. Start is taken again in
// the cycle done is shown. Cost is one memory read per held entry,
// shifting through the write port. Reset (arst_n low) empties the store;
// memory contents are not cleared.
// ----------------------------------------------------------------------------
// Sorted list store: top level
// Ascending multiset of signed values with insert and remove-first-equal,
// held in one RAM and updated by a single read-modify-write pass.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove #(
	parameter int CAPACITY = slri_pkg::DEFAULT_CAPACITY
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  slri_pkg::req_t  cmd,
	output logic            done,
	output slri_pkg::resp_t result
);

	`include "sorted_list_insert_remove_macros.svh"

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_TAIL = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t                               state_q;
	logic [CW-1:0]                        count_q;
	logic [CW-1:0]                        rd_q;
	logic                                 found_q;
	logic                                 full_q;
	logic                                 req_q;
	logic signed [slri_pkg::VALUE_W-1:0]  value_q;
	logic signed [slri_pkg::VALUE_W-1:0]  carry_q;
	logic                                 vld_s1;
	logic [AW-1:0]                        idx_s1;
	logic                                 done_q;
	slri_pkg::resp_t                      result_q;

	logic                                 accept;
	logic                                 rd_en;
	logic                                 hit;
	logic                                 last;
	logic                                 is_full;
	logic [CW-1:0]                        cnt_fin;
	logic                                 mem_we;
	logic [AW-1:0]                        mem_waddr;
	logic signed [slri_pkg::VALUE_W-1:0]  mem_wdata;
	logic signed [slri_pkg::VALUE_W-1:0]  rdata;

	assign accept  = start && (state_q == ST_IDLE);
	assign busy    = (state_q != ST_IDLE);
	assign is_full = (count_q == CW'(CAPACITY));
	assign rd_en   = (state_q == ST_SCAN) && (rd_q < count_q);
	assign last    = vld_s1 && (CW'(idx_s1) == (count_q - CW'(1)));

	// insertion point is the first entry not below the value; a remove hits the first equal one
	assign hit = vld_s1 && !found_q &&
		((req_q == slri_pkg::REQ_INSERT) ? (rdata >= value_q) : (rdata == value_q));

	assign cnt_fin = ((req_q == slri_pkg::REQ_REMOVE) && found_q) ?
		(count_q - CW'(1)) : count_q;

	// write port: shift during scan, tail write for inserts
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_s1;
		mem_wdata = carry_q;
		case (state_q)
			ST_SCAN: begin
				if (req_q == slri_pkg::REQ_INSERT) begin
					mem_we    = vld_s1 && (found_q || hit);
					mem_waddr = idx_s1;
					mem_wdata = found_q ? carry_q : value_q;
				end else begin
					mem_we    = vld_s1 && found_q;
					mem_waddr = idx_s1 - AW'(1);
					mem_wdata = rdata;
				end
			end
			ST_TAIL: begin
				mem_we    = 1'b1;
				mem_waddr = count_q[AW-1:0];
				mem_wdata = found_q ? carry_q : value_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			rd_q     <= '0;
			found_q  <= 1'b0;
			full_q   <= 1'b0;
			vld_s1   <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			vld_s1 <= rd_en;
			if (rd_en) begin
				rd_q <= rd_q + CW'(1);
			end
			if (hit) begin
				found_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rd_q    <= '0;
						found_q <= 1'b0;
						full_q  <= 1'b0;
						if ((cmd.req_type == slri_pkg::REQ_INSERT) && is_full) begin
							full_q  <= 1'b1;
							state_q <= ST_FIN;
						end else if (count_q == '0) begin
							state_q <= (cmd.req_type == slri_pkg::REQ_INSERT) ?
								ST_TAIL : ST_FIN;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (last) begin
						state_q <= (req_q == slri_pkg::REQ_INSERT) ? ST_TAIL : ST_FIN;
					end
				end
				ST_TAIL: begin
					count_q <= count_q + CW'(1);
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					count_q <= cnt_fin;
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request capture, shift carry and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q   <= cmd.req_type;
			value_q <= cmd.value;
		end
		if (vld_s1 && (found_q || hit)) begin
			carry_q <= rdata;
		end
		idx_s1 <= rd_q[AW-1:0];
		if (state_q == ST_FIN) begin
			result_q.entry_count <= 7'(cnt_fin);
			if (full_q) begin
				result_q.status <= slri_pkg::STATUS_FULL;
			end else if ((req_q == slri_pkg::REQ_REMOVE) && !found_q) begin
				result_q.status <= slri_pkg::STATUS_NOTFOUND;
			end else begin
				result_q.status <= slri_pkg::STATUS_DONE;
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

	slri_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (rd_en),
		.raddr (rd_q[AW-1:0]),
		.rdata (rdata)
	);

	// checks
	`SLRI_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(CAPACITY))
	`SLRI_ASSERT_NXT(a_fin_done, clk, arst_n, state_q == ST_FIN, done_q && !busy)
	`SLRI_ASSERT_IMP(a_scan_wr_range, clk, arst_n, mem_we && (state_q == ST_SCAN),
		CW'(mem_waddr) < count_q)
	`SLRI_ASSERT_IMP(a_tail_not_full, clk, arst_n, state_q == ST_TAIL, !is_full)

endmodule

[dv/sorted_list_insert_remove_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list store: testbench
// Drives insert and remove commands, a directed table first and then random
// fill/drain traffic, and checks every done strobe against a queue-based
// sorted multiset kept alongside the block or a typed-in table outcome.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove_test;

	localparam int STORE_DEPTH  = slri_pkg::DEFAULT_CAPACITY;
	localparam int RANDOM_ITEMS = 1500;
	localparam int CYCLE_LIMIT  = 1000000;

	localparam logic signed [slri_pkg::VALUE_W-1:0] VAL_MIN = 32'sh80000000;
	localparam logic signed [slri_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7FFFFFFF;

	// one row of the directed table; fixed_result marks a typed-in outcome
	typedef struct {
		logic                                req_type;
		logic signed [slri_pkg::VALUE_W-1:0] value;
		bit                                  fixed_result;
		logic [1:0]                          status;
		int                                  entry_count;
	} plan_row_t;

	localparam int PLAN_ROWS = 25;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	slri_pkg::req_t   cmd;
	logic             done;
	slri_pkg::resp_t  result;

	// shadow copy of the store, ascending
	logic signed [slri_pkg::VALUE_W-1:0] held_vals[$];
	// outcomes still owed by the block, oldest first
	slri_pkg::resp_t                     owed_results[$];

	int error_count = 0;
	int cycle_count = 0;
	int no_gap_run  = 0;
	bit fill_mode   = 1'b1;

	plan_row_t plan [PLAN_ROWS] = '{
		'{slri_pkg::REQ_REMOVE, 32'sd0,        1'b1, slri_pkg::STATUS_NOTFOUND, 0},
		'{slri_pkg::REQ_INSERT, VAL_MAX,       1'b1, slri_pkg::STATUS_DONE,     1},
		'{slri_pkg::REQ_INSERT, VAL_MIN,       1'b1, slri_pkg::STATUS_DONE,     2},
		'{slri_pkg::REQ_INSERT, 32'sd0,        1'b1, slri_pkg::STATUS_DONE,     3},
		'{slri_pkg::REQ_INSERT, -32'sd1,       1'b0, slri_pkg::STATUS_DONE,     0},
		'{slri_pkg::REQ_INSERT, 32'sd1,        1'b0, slri_pkg::STATUS_DONE,     0},
		'{slri_pkg::REQ_INSERT, 32'sd0,        1'b0, slri_pkg::STATUS_DONE,     0},
		'{slri_pkg::REQ_INSERT, VAL_MAX,       1'b0, slri_pkg::STATUS_DONE,     0},
		'{slri_pkg::REQ_REMOVE, 32'sd5,        1'b1, slri_pkg::STATUS_NOTFOUND, 7},
		'{slri_pkg::REQ_REMOVE, 32'sd0,        1'b0, slri_pkg::STATUS_DONE,     0},
		'{slri_pkg::REQ_REMOVE, 32'sd0,        1'b0, slri_pkg::STATUS_DONE,     0},
		'{slri_pkg::REQ_REMOVE, 32'sd0,        1'b1, slri_pkg::STATUS_NOTFOUND, 5},
		'{slri_pkg::REQ_REMOVE, VAL_MIN,       1'b0, slri_pkg::STATUS_DONE,     0},
		'{slri_pkg::REQ_REMOVE, VAL_MIN,       1'b1, slri_pkg::STATUS_NOTFOUND, 4},
		'{slri_pkg::REQ_INSERT, 32'sh80000001, 1'b0, slri_pkg::STATUS_DONE,     0},
		'{slri_pkg::REQ_REMOVE, VAL_MAX,       1'b0, slri_pkg::STATUS_DONE,     0},
		'{slri_pkg::REQ_REMOVE, VAL_MAX,       1'b0, slri_pkg::STATUS_DONE,     0},
		'{slri_pkg::REQ_REMOVE, -32'sd1,       1'b0, slri_pkg::STATUS_DONE,     0},
		'{slri_pkg::REQ_REMOVE, 32'sd1,        1'b0, slri_pkg::STATUS_DONE,     0},
		'{slri_pkg::REQ_REMOVE, 32'sh80000001, 1'b1, slri_pkg::STATUS_DONE,     0},
		'{slri_pkg::REQ_REMOVE, VAL_MAX,       1'b1, slri_pkg::STATUS_NOTFOUND, 0},
		'{slri_pkg::REQ_INSERT, 32'sh55555555, 1'b0, slri_pkg::STATUS_DONE,     0},
		'{slri_pkg::REQ_INSERT, 32'shAAAAAAAA, 1'b0, slri_pkg::STATUS_DONE,     0},
		'{slri_pkg::REQ_REMOVE, 32'sh55555554, 1'b0, slri_pkg::STATUS_DONE,     0},
		'{slri_pkg::REQ_REMOVE, 32'shAAAAAAAA, 1'b0, slri_pkg::STATUS_DONE,     0}
	};

	sorted_list_insert_remove #(
		.CAPACITY(STORE_DEPTH)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	// clock
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// applies one command to the shadow store, returns the outcome
	function automatic slri_pkg::resp_t apply_to_shadow(slri_pkg::req_t c);
		slri_pkg::resp_t outcome;
		int              pos;
		pos = 0;
		if (c.req_type == slri_pkg::REQ_INSERT) begin
			if (held_vals.size() >= STORE_DEPTH) begin
				outcome.status = slri_pkg::STATUS_FULL;
			end else begin
				while (pos < held_vals.size() && held_vals[pos] < $signed(c.value))
					pos++;
				held_vals.insert(pos, c.value);
				outcome.status = slri_pkg::STATUS_DONE;
			end
		end else begin
			while (pos < held_vals.size() && held_vals[pos] != $signed(c.value))
				pos++;
			if (pos >= held_vals.size()) begin
				outcome.status = slri_pkg::STATUS_NOTFOUND;
			end else begin
				held_vals.delete(pos);
				outcome.status = slri_pkg::STATUS_DONE;
			end
		end
		outcome.entry_count = 7'(held_vals.size());
		return outcome;
	endfunction

	// value mix: wide random, extremes, and a narrow band for duplicates
	function automatic logic signed [slri_pkg::VALUE_W-1:0] draw_value();
		logic signed [slri_pkg::VALUE_W-1:0] v;
		case ($urandom_range(0, 3))
			0: v = $urandom();
			1: begin
				case ($urandom_range(0, 5))
					0: v = VAL_MIN;
					1: v = VAL_MAX;
					2: v = 32'sd0;
					3: v = -32'sd1;
					4: v = VAL_MIN + 32'sd1;
					default: v = VAL_MAX - 32'sd1;
				endcase
			end
			default: v = $signed($urandom_range(0, 15)) - 32'sd8;
		endcase
		return v;
	endfunction

	// one command transfer: idle gap, then hold start until taken
	task automatic send_cmd(slri_pkg::req_t c, bit fixed_result,
		slri_pkg::resp_t fixed_outcome);
		int              gap;
		slri_pkg::resp_t outcome;
		if (no_gap_run > 0) begin
			gap = 0;
			no_gap_run--;
		end else begin
			gap = $urandom_range(0, 11);
			if ($urandom_range(0, 39) == 0)
				no_gap_run = $urandom_range(10, 40);
		end
		repeat (gap) begin
			start <= 1'b0;
			cmd   <= {1'($urandom_range(0, 1)), $urandom()};
			@(posedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy !== 1'b0);
		outcome = apply_to_shadow(c);
		owed_results.push_back(fixed_result ? fixed_outcome : outcome);
	endtask

	// result checker
	always @(posedge clk) begin
		slri_pkg::resp_t want;
		if (arst_n && done === 1'b1) begin
			if (owed_results.size() == 0) begin
				$error("unexpected result: status %0d, entry_count %0d",
					result.status, result.entry_count);
				error_count++;
			end else begin
				want = owed_results.pop_front();
				if (result.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, result.status);
					error_count++;
				end
				if (result.entry_count !== want.entry_count) begin
					$error("entry_count: expected %0d, actual %0d",
						want.entry_count, result.entry_count);
					error_count++;
				end
			end
		end
	end

	// run limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("sorted_list_insert_remove_test: done, errors");
		$finish;
	end

	// stimulus
	initial begin
		slri_pkg::req_t  c;
		slri_pkg::resp_t fixed;
		arst_n = 1'b0;
		start  = 1'b0;
		cmd    = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < PLAN_ROWS; i++) begin
			c.req_type         = plan[i].req_type;
			c.value            = plan[i].value;
			fixed.status       = plan[i].status;
			fixed.entry_count  = 7'(plan[i].entry_count);
			send_cmd(c, plan[i].fixed_result, fixed);
		end

		// random fill/drain cycles: the store swings between empty and full
		fixed = '0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (fill_mode && held_vals.size() == STORE_DEPTH && $urandom_range(0, 2) == 0)
				fill_mode = 1'b0;
			else if (!fill_mode && held_vals.size() == 0 && $urandom_range(0, 2) == 0)
				fill_mode = 1'b1;
			if ($urandom_range(0, 7) == 0)
				c.req_type = fill_mode ? slri_pkg::REQ_REMOVE : slri_pkg::REQ_INSERT;
			else
				c.req_type = fill_mode ? slri_pkg::REQ_INSERT : slri_pkg::REQ_REMOVE;
			// removes mostly target a held entry
			if (c.req_type == slri_pkg::REQ_REMOVE && held_vals.size() > 0 &&
				$urandom_range(0, 3) != 0)
				c.value = held_vals[$urandom_range(0, held_vals.size() - 1)];
			else
				c.value = draw_value();
			send_cmd(c, 1'b0, fixed);
		end
		start <= 1'b0;

		// drain outstanding results, then watch for strays
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (STORE_DEPTH + 8) @(posedge clk);

		if (error_count == 0)
			$display("sorted_list_insert_remove_test: done, clean");
		else
			$display("sorted_list_insert_remove_test: done, errors");
		$finish;
	end

endmodule

[sim.f]
+incdir+design
design/slri_pkg.sv
design/slri_mem.sv
design/sorted_list_insert_remove.sv
dv/sorted_list_insert_remove_test.sv
